// ----- sv/utfr_pkg.sv -----
// shared types, constants and the field-walk microprogram of the tag frame receiver
// no dependencies
`default_nettype none

package utfr_pkg;

    localparam int FRAME_BYTES = 128;
    localparam int FRAME_AW    = $clog2(FRAME_BYTES);
    localparam int N_FIELDS    = 35;
    localparam int FIELD_IDX_W = 6;
    localparam int VALUE_W     = 32;

    localparam logic [7:0] HDR0 = 8'h55;
    localparam logic [7:0] HDR1 = 8'h01;
    localparam logic [7:0] SUM_HDR = 8'(HDR0 + HDR1);

    localparam logic [FRAME_AW-1:0] HDR0_POS       = FRAME_AW'(0);
    localparam logic [FRAME_AW-1:0] HDR1_POS       = FRAME_AW'(1);
    localparam logic [FRAME_AW-1:0] FIRST_BODY_POS = FRAME_AW'(2);
    localparam logic [FRAME_AW-1:0] LAST_POS       = FRAME_AW'(FRAME_BYTES - 1);

    localparam logic [FIELD_IDX_W-1:0] LAST_FIELD = FIELD_IDX_W'(N_FIELDS - 1);

    // byte count minus one of a field
    localparam logic [1:0] NB_1 = 2'd0;
    localparam logic [1:0] NB_2 = 2'd1;
    localparam logic [1:0] NB_3 = 2'd2;
    localparam logic [1:0] NB_4 = 2'd3;

    typedef enum logic [1:0] {
        RX_HUNT,
        RX_HDR,
        RX_BODY
    } t_rx_phase;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_READ,
        SEQ_CAPT,
        SEQ_EMIT
    } t_seq_state;

    typedef struct packed {
        logic go;
        logic err;
    } t_seq_start;

    typedef struct packed {
        logic [FIELD_IDX_W-1:0] field_index;
        logic [VALUE_W-1:0]     field_value;
        logic                   status;
        logic                   last;
    } t_result;

    typedef struct packed {
        logic [FRAME_AW-1:0] offset;
        logic [1:0]          nbm1;
        logic                sext;
        logic                last;
    } t_ucode;

    function automatic t_ucode uc_word(input int off, input logic [1:0] nbm1,
                                       input logic sext, input logic last);
        t_ucode w;
        w.offset = FRAME_AW'(off);
        w.nbm1   = nbm1;
        w.sext   = sext;
        w.last   = last;
        return w;
    endfunction

    function automatic t_ucode ucode_rom(input logic [FIELD_IDX_W-1:0] a);
        t_ucode w;
        case (a)
            6'd0:    w = uc_word(2,   NB_1, 1'b0, 1'b0);
            6'd1:    w = uc_word(3,   NB_1, 1'b0, 1'b0);
            6'd2:    w = uc_word(4,   NB_3, 1'b1, 1'b0);
            6'd3:    w = uc_word(7,   NB_3, 1'b1, 1'b0);
            6'd4:    w = uc_word(10,  NB_3, 1'b1, 1'b0);
            6'd5:    w = uc_word(13,  NB_3, 1'b1, 1'b0);
            6'd6:    w = uc_word(16,  NB_3, 1'b1, 1'b0);
            6'd7:    w = uc_word(19,  NB_3, 1'b1, 1'b0);
            6'd8:    w = uc_word(22,  NB_3, 1'b1, 1'b0);
            6'd9:    w = uc_word(25,  NB_3, 1'b1, 1'b0);
            6'd10:   w = uc_word(28,  NB_3, 1'b1, 1'b0);
            6'd11:   w = uc_word(31,  NB_3, 1'b1, 1'b0);
            6'd12:   w = uc_word(34,  NB_3, 1'b1, 1'b0);
            6'd13:   w = uc_word(37,  NB_3, 1'b1, 1'b0);
            6'd14:   w = uc_word(40,  NB_3, 1'b1, 1'b0);
            6'd15:   w = uc_word(43,  NB_3, 1'b1, 1'b0);
            6'd16:   w = uc_word(46,  NB_4, 1'b0, 1'b0);
            6'd17:   w = uc_word(50,  NB_4, 1'b0, 1'b0);
            6'd18:   w = uc_word(54,  NB_4, 1'b0, 1'b0);
            6'd19:   w = uc_word(58,  NB_4, 1'b0, 1'b0);
            6'd20:   w = uc_word(62,  NB_4, 1'b0, 1'b0);
            6'd21:   w = uc_word(66,  NB_4, 1'b0, 1'b0);
            6'd22:   w = uc_word(82,  NB_2, 1'b1, 1'b0);
            6'd23:   w = uc_word(84,  NB_2, 1'b1, 1'b0);
            6'd24:   w = uc_word(86,  NB_2, 1'b1, 1'b0);
            6'd25:   w = uc_word(88,  NB_4, 1'b0, 1'b0);
            6'd26:   w = uc_word(92,  NB_4, 1'b0, 1'b0);
            6'd27:   w = uc_word(96,  NB_4, 1'b0, 1'b0);
            6'd28:   w = uc_word(100, NB_4, 1'b0, 1'b0);
            6'd29:   w = uc_word(108, NB_4, 1'b0, 1'b0);
            6'd30:   w = uc_word(112, NB_4, 1'b0, 1'b0);
            6'd31:   w = uc_word(117, NB_1, 1'b0, 1'b0);
            6'd32:   w = uc_word(118, NB_1, 1'b0, 1'b0);
            6'd33:   w = uc_word(119, NB_1, 1'b0, 1'b0);
            6'd34:   w = uc_word(120, NB_2, 1'b0, 1'b1);
            default: w = uc_word(120, NB_2, 1'b0, 1'b1);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- sv/utfr_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module utfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/utfr_front.sv -----
// receive front: header hunt, frame byte store writes and running checksum
// depends on utfr_pkg
`default_nettype none

module utfr_front
    import utfr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [7:0]          i_rx_byte,
    output logic                     o_we,
    output logic      [FRAME_AW-1:0] o_waddr,
    output logic      [7:0]          o_wdata,
    output t_seq_start               o_start
);

    t_rx_phase           r_phase, n_phase;
    logic [FRAME_AW-1:0] r_pos, n_pos;
    logic [7:0]          r_sum, n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= RX_HUNT;
            r_pos   <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_pos         = r_pos;
        n_sum         = r_sum;
        o_we          = 1'b0;
        o_waddr       = r_pos;
        o_wdata       = i_rx_byte;
        o_start.go    = 1'b0;
        o_start.err   = 1'b0;
        if (i_accept) begin
            case (r_phase)
                RX_HUNT: begin
                    if (i_rx_byte == HDR0) begin
                        o_we    = 1'b1;
                        o_waddr = HDR0_POS;
                        n_phase = RX_HDR;
                    end
                end
                RX_HDR: begin
                    if (i_rx_byte == HDR1) begin
                        o_we    = 1'b1;
                        o_waddr = HDR1_POS;
                        n_sum   = SUM_HDR;
                        n_pos   = FIRST_BODY_POS;
                        n_phase = RX_BODY;
                    end else begin
                        n_phase = RX_HUNT;
                    end
                end
                RX_BODY: begin
                    o_we = 1'b1;
                    if (r_pos != LAST_POS) begin
                        n_sum = r_sum + i_rx_byte;
                        n_pos = r_pos + 1'b1;
                    end else begin
                        n_phase     = RX_HUNT;
                        n_pos       = '0;
                        o_start.go  = 1'b1;
                        o_start.err = (i_rx_byte != r_sum);
                    end
                end
                default: begin
                    n_phase = RX_HUNT;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/utfr_seq.sv -----
// microcoded field walker: steps through the field program, reads the frame
// store a byte at a time and assembles each result; depends on utfr_pkg
`default_nettype none

module utfr_seq
    import utfr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_seq_start          i_start,
    input  wire logic                i_out_free,
    input  wire logic [7:0]          i_rdata,
    output logic                     o_re,
    output logic      [FRAME_AW-1:0] o_raddr,
    output logic                     o_busy,
    output logic                     o_emit,
    output t_result                  o_result
);

    t_seq_state             r_state, n_state;
    logic [FIELD_IDX_W-1:0] r_upc, n_upc;
    logic [1:0]             r_bcnt, n_bcnt;
    logic [VALUE_W-1:0]     r_acc, n_acc;
    logic                   r_err, n_err;
    t_ucode                 uc;
    logic [VALUE_W-1:0]     ext_value;

    assign uc = ucode_rom(r_upc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_upc   <= '0;
            r_bcnt  <= '0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_upc   <= n_upc;
            r_bcnt  <= n_bcnt;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    always_comb begin
        ext_value = r_acc;
        if (uc.sext) begin
            case (uc.nbm1)
                NB_3:    ext_value = {{8{r_acc[23]}}, r_acc[23:0]};
                NB_2:    ext_value = {{16{r_acc[15]}}, r_acc[15:0]};
                default: ext_value = r_acc;
            endcase
        end
    end

    always_comb begin
        n_state  = r_state;
        n_upc    = r_upc;
        n_bcnt   = r_bcnt;
        n_acc    = r_acc;
        n_err    = r_err;
        o_re     = 1'b0;
        o_raddr  = uc.offset + FRAME_AW'(r_bcnt);
        o_emit   = 1'b0;
        o_busy   = (r_state != SEQ_IDLE);
        o_result.field_index = r_upc;
        o_result.field_value = ext_value;
        o_result.status      = 1'b0;
        o_result.last        = uc.last;
        if (r_err) begin
            o_result.field_index = '0;
            o_result.field_value = '0;
            o_result.status      = 1'b1;
            o_result.last        = 1'b1;
        end
        case (r_state)
            SEQ_IDLE: begin
                if (i_start.go) begin
                    n_upc   = '0;
                    n_bcnt  = '0;
                    n_acc   = '0;
                    n_err   = i_start.err;
                    n_state = i_start.err ? SEQ_EMIT : SEQ_READ;
                end
            end
            SEQ_READ: begin
                o_re    = 1'b1;
                n_state = SEQ_CAPT;
            end
            SEQ_CAPT: begin
                case (r_bcnt)
                    2'd0:    n_acc[7:0]   = i_rdata;
                    2'd1:    n_acc[15:8]  = i_rdata;
                    2'd2:    n_acc[23:16] = i_rdata;
                    default: n_acc[31:24] = i_rdata;
                endcase
                if (r_bcnt == uc.nbm1) begin
                    n_state = SEQ_EMIT;
                end else begin
                    n_bcnt  = r_bcnt + 1'b1;
                    n_state = SEQ_READ;
                end
            end
            SEQ_EMIT: begin
                o_emit = 1'b1;
                if (i_out_free) begin
                    if (r_err || uc.last) begin
                        n_err   = 1'b0;
                        n_state = SEQ_IDLE;
                    end else begin
                        n_upc   = r_upc + 1'b1;
                        n_bcnt  = '0;
                        n_acc   = '0;
                        n_state = SEQ_READ;
                    end
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/uwb_tag_frame_receiver_unit.sv -----
// top level of the tag frame receiver: front, frame store, field walker, output register
// depends on utfr_pkg, utfr_ram, utfr_front, utfr_seq
`default_nettype none

// Receives one byte per transaction and accepts a byte every cycle while a frame is being
// collected. Frames start with 0x55 0x01 and are 128 bytes long; byte 127 is the 8-bit
// additive checksum of bytes 0..126. After the checksum byte the input stalls while the
// result transactions are produced: a bad frame gives one error result, a good frame
// gives 35 field results, with each frame byte of a field read through the single read
// port of the frame store before the field is handed over; the walk also waits while
// the output is stalled. The last result of a frame may still wait in the output register
// while the next frame's bytes are taken. No clearing pass after reset.
module uwb_tag_frame_receiver_unit
    import utfr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [7:0]             i_rx_byte,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic      [FIELD_IDX_W-1:0] o_field_index,
    output logic      [VALUE_W-1:0]     o_field_value,
    output logic                        o_status,
    output logic                        o_last
);

    logic                accept;
    logic                we;
    logic [FRAME_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [FRAME_AW-1:0] raddr;
    logic [7:0]          rdata;
    t_seq_start          start;
    logic                busy;
    logic                emit;
    logic                out_free;
    t_result             result;
    logic                r_out_valid;
    t_result             r_out;

    assign o_stall  = busy;
    assign accept   = i_valid && !busy;
    assign out_free = !r_out_valid || !i_stall;

    utfr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_start   (start)
    );

    utfr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    utfr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_free (out_free),
        .i_rdata    (rdata),
        .o_re       (re),
        .o_raddr    (raddr),
        .o_busy     (busy),
        .o_emit     (emit),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit && out_free) begin
            r_out <= result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_field_index = r_out.field_index;
    assign o_field_value = r_out.field_value;
    assign o_status      = r_out.status;
    assign o_last        = r_out.last;

endmodule

`default_nettype wire

// ----- sv/utfr_checker.sv -----
// port-level checks of the tag frame receiver and the bind that attaches them
// depends on utfr_pkg and uwb_tag_frame_receiver_unit
`default_nettype none

module utfr_checker
    import utfr_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_valid,
    input wire logic                   i_stall,
    input wire logic [FIELD_IDX_W-1:0] o_field_index,
    input wire logic [VALUE_W-1:0]     o_field_value,
    input wire logic                   o_status,
    input wire logic                   o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_field_index)
            && $stable(o_field_value) && $stable(o_status) && $stable(o_last))
        else $error("stalled result changed");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_last && o_field_index == '0 && o_field_value == '0)
        else $error("malformed checksum error result");

    a_last_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_status |-> (o_last == (o_field_index == LAST_FIELD)))
        else $error("last flag does not match final field");

    a_byte_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_status && (o_field_index == 6'd0 || o_field_index == 6'd1
            || o_field_index == 6'd31 || o_field_index == 6'd32 || o_field_index == 6'd33)
        |-> o_field_value[31:8] == '0)
        else $error("byte field not zero-extended");

endmodule

bind uwb_tag_frame_receiver_unit utfr_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_field_index (o_field_index),
    .o_field_value (o_field_value),
    .o_status      (o_status),
    .o_last        (o_last)
);

`default_nettype wire
